// ===== src/cbq_pkg.sv =====
package cbq_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 18;
    localparam int VAL_W       = 44;
    localparam int ACC_W       = 64;
    localparam int OUT_W       = 64;
    localparam int HALF_W      = VAL_W / 2;
    localparam int OP_W        = HALF_W + 1;
    localparam int PROD_W      = COEF_W + OP_W;
    localparam int INPUT_SHIFT = 8;

    localparam int MAX_SECTIONS       = 4;
    localparam int N_COEF             = 2 * MAX_SECTIONS;
    localparam int SEC_W              = $clog2(MAX_SECTIONS);
    localparam int COEF_IDX_W         = $clog2(N_COEF);
    localparam int CFG_IDX_W          = COEF_IDX_W + 1;
    localparam int DLY_ADDR_W         = 1 + SEC_W + 1;
    localparam int DEF_SECTIONS       = 4;
    localparam int DEF_COEF_FRAC_BITS = 16;

    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_LAST = 3'd4;

    // delay slot within a section
    localparam logic SLOT_Z1 = 1'b0;
    localparam logic SLOT_Z2 = 1'b1;

    typedef logic signed [VAL_W-1:0]  t_val;
    typedef logic signed [COEF_W-1:0] t_coef;

    localparam t_coef COEF_RESET [N_COEF] = '{
        -18'sd128765, 18'sd64822, -18'sd127906, 18'sd63517,
        -18'sd127533, 18'sd62534, -18'sd127428, 18'sd62004
    };

    localparam logic signed [ACC_W-1:0] VAL_MAX = ACC_W'(t_val'({1'b0, {(VAL_W-1){1'b1}}}));
    localparam logic signed [ACC_W-1:0] VAL_MIN = ACC_W'(t_val'({1'b1, {(VAL_W-1){1'b0}}}));

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_re;
        logic signed [SAMPLE_W-1:0] sample_im;
        logic                       clear;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_re;
        logic signed [OUT_W-1:0] out_im;
        logic                    saturated;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic issue;
        logic hi;
    } t_mac_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_MUL,
        ST_W,
        ST_Y,
        ST_DONE
    } t_state;

    function automatic t_val to_val(input logic signed [SAMPLE_W-1:0] s);
        return {{(VAL_W-SAMPLE_W-INPUT_SHIFT){s[SAMPLE_W-1]}}, s, {INPUT_SHIFT{1'b0}}};
    endfunction

    function automatic logic is_ovf(input logic signed [ACC_W-1:0] v);
        return (v > VAL_MAX) || (v < VAL_MIN);
    endfunction

    function automatic t_val sat_val(input logic signed [ACC_W-1:0] v);
        t_val r;
        if (v > VAL_MAX) begin
            r = VAL_MAX[VAL_W-1:0];
        end else if (v < VAL_MIN) begin
            r = VAL_MIN[VAL_W-1:0];
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== src/cbq_if.sv =====
interface cbq_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/cbq_mac.sv =====
module cbq_mac
    import cbq_pkg::*;
#(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_ctl                i_ctl,
    input  t_coef                   i_coef,
    input  t_val                    i_z,
    output logic signed [ACC_W-1:0] o_fb
);

    logic signed [OP_W-1:0]   w_op;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_half;
    logic signed [ACC_W-1:0]  w_addend;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic                     r_prod_hi;
    logic signed [ACC_W-1:0]  r_acc;

    // 44-bit delay split in halves: low half unsigned, high half signed
    assign w_op = i_ctl.hi ? {i_z[VAL_W-1], i_z[VAL_W-1:HALF_W]}
                           : {1'b0, i_z[HALF_W-1:0]};
    assign w_prod = i_coef * w_op;

    assign w_half   = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    assign w_addend = r_prod_hi ? (ACC_W'(r_prod) <<< HALF_W) : ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod    <= w_prod;
        r_prod_hi <= i_ctl.hi;
        if (i_ctl.start) begin
            r_acc <= w_half;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + w_addend;
        end
    end

    // arithmetic shift of the rounded sum is a floor division
    assign o_fb = r_acc >>> COEF_FRAC_BITS;

endmodule

// ===== src/cbq_dly.sv =====
module cbq_dly
    import cbq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clr,
    input  logic                  i_we,
    input  logic [DLY_ADDR_W-1:0] i_waddr,
    input  t_val                  i_wdata,
    input  logic [DLY_ADDR_W-1:0] i_raddr,
    output t_val                  o_rdata
);

    localparam int DEPTH = 2 ** DLY_ADDR_W;

    t_val             r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    t_val             r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_clr) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // an entry never written since clear reads as zero
    always_ff @(posedge i_clk) begin
        r_rdata <= r_vld[i_raddr] ? r_mem[i_raddr] : '0;
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/complex_biquad_cascade_lowpass.sv =====
// Each item runs its real part, then its imaginary part, through every section before the output register is loaded.
// A new item is taken only once the last one is done; ready only while idle.
// One shared 18x23 multiplier: per section and part 4 partial products.
// Output register holds a result until taken; a new item is accepted meanwhile.
// Reset (i_rst_n, synchronous): coefficients to defaults, all delays read as zero.
module complex_biquad_cascade_lowpass
    import cbq_pkg::*;
#(
    parameter int SECTIONS       = DEF_SECTIONS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data,
    cbq_if.sink                  i_in,
    cbq_if.source                o_out
);

    t_state                  r_state, n_state;
    logic                    r_part;
    logic [SEC_W-1:0]        r_sec;
    logic [STEP_W-1:0]       r_step;
    t_coef                   r_coef [N_COEF];
    logic                    r_out_vld;
    t_out_item               r_out;
    t_val                    r_x;
    t_val                    r_y_re;
    logic [SAMPLE_W-1:0]     r_im_in;
    t_val                    r_z1, r_z2, r_w;
    logic                    r_sat;

    t_mac_ctl                w_mac;
    logic [DLY_ADDR_W-1:0]   w_rd_addr;
    logic                    w_wr_en;
    logic [DLY_ADDR_W-1:0]   w_wr_addr;
    t_val                    w_wr_data;
    t_val                    w_rd_data;
    logic signed [ACC_W-1:0] w_fb;
    logic signed [ACC_W-1:0] w_diff;
    logic signed [ACC_W-1:0] w_sum;
    t_val                    w_w, w_y;
    t_coef                   w_coef;
    t_val                    w_zop;
    logic                    w_in_acc;
    logic                    w_sec_last;
    logic                    w_out_free;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;
    assign w_out_free  = !r_out_vld || o_out.ready;
    assign w_sec_last  = (r_sec == SEC_W'(SECTIONS - 1));

    assign w_coef = r_coef[{r_sec, r_step[1]}];
    assign w_zop  = r_step[1] ? r_z2 : r_z1;

    assign w_diff = ACC_W'(r_x) - w_fb;
    assign w_w    = sat_val(w_diff);
    assign w_sum  = ACC_W'(r_w) + (ACC_W'(r_z1) <<< 1) + ACC_W'(r_z2);
    assign w_y    = sat_val(w_sum);

    cbq_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac),
        .i_coef  (w_coef),
        .i_z     (w_zop),
        .o_fb    (w_fb)
    );

    cbq_dly u_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (w_in_acc && i_in.data.clear),
        .i_we    (w_wr_en),
        .i_waddr (w_wr_addr),
        .i_wdata (w_wr_data),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in.valid) n_state = ST_RD1;
            ST_RD1:  n_state = ST_RD2;
            ST_RD2:  n_state = ST_MUL;
            ST_MUL:  if (r_step == STEP_LAST) n_state = ST_W;
            ST_W:    n_state = ST_Y;
            ST_Y: begin
                if (w_sec_last && r_part) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_RD1;
                end
            end
            ST_DONE: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_mac     = '0;
        w_rd_addr = {r_part, r_sec, SLOT_Z1};
        w_wr_en   = 1'b0;
        w_wr_addr = {r_part, r_sec, SLOT_Z1};
        w_wr_data = w_w;
        case (r_state)
            ST_RD1: w_mac.start = 1'b1;
            ST_RD2: w_rd_addr = {r_part, r_sec, SLOT_Z2};
            ST_MUL: begin
                w_mac.issue = (r_step != STEP_LAST);
                w_mac.hi    = r_step[0];
            end
            ST_W: w_wr_en = 1'b1;
            ST_Y: begin
                w_wr_en   = 1'b1;
                w_wr_addr = {r_part, r_sec, SLOT_Z2};
                w_wr_data = r_z1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_part    <= 1'b0;
            r_sec     <= '0;
            r_step    <= '0;
            r_out_vld <= 1'b0;
            r_coef    <= COEF_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(N_COEF))) begin
                r_coef[i_cfg_idx[COEF_IDX_W-1:0]] <= i_cfg_data;
            end
            case (r_state)
                ST_IDLE: begin
                    r_part <= 1'b0;
                    r_sec  <= '0;
                end
                ST_RD1: r_step <= '0;
                ST_MUL: r_step <= r_step + STEP_W'(1);
                ST_Y: begin
                    if (w_sec_last) begin
                        r_sec  <= '0;
                        r_part <= 1'b1;
                    end else begin
                        r_sec <= r_sec + SEC_W'(1);
                    end
                end
                default: ;
            endcase
            if (r_state == ST_DONE && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    r_x     <= to_val(i_in.data.sample_re);
                    r_im_in <= i_in.data.sample_im;
                    r_sat   <= 1'b0;
                end
            end
            ST_RD2: r_z1 <= w_rd_data;
            ST_MUL: if (r_step == '0) r_z2 <= w_rd_data;
            ST_W: begin
                r_w   <= w_w;
                r_sat <= r_sat | is_ovf(w_diff);
            end
            ST_Y: begin
                r_sat <= r_sat | is_ovf(w_sum);
                // real part done: park it and start the imaginary part
                if (w_sec_last && !r_part) begin
                    r_y_re <= w_y;
                    r_x    <= to_val(r_im_in);
                end else begin
                    r_x <= w_y;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    r_out.out_re    <= OUT_W'(r_y_re);
                    r_out.out_im    <= OUT_W'(r_x);
                    r_out.saturated <= r_sat;
                end
            end
            default: ;
        endcase
    end

endmodule
